/* sv/pidtc_pkg.sv */
// Package with the constants, types and helper functions of the trapezoidal PID core.
package pidtc_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int DT_W      = 24;
    localparam int MAG_W     = DATA_W + 1;
    localparam int OPA_W     = 2 * DATA_W + 1;
    localparam int CHUNK_W   = DATA_W / 2;
    localparam int PP_W      = OPA_W + CHUNK_W;
    localparam int ACC_W     = OPA_W + DT_W;
    localparam int I_SHIFT   = FRAC_BITS + DT_W + 1;
    localparam int D_SHIFT   = DT_W - FRAC_BITS;
    localparam int QUO_W     = DATA_W;
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 3;
    localparam int CNT_W     = $clog2(QUO_W);

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_PERIOD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRATOR_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT      = 3'd5;

    localparam logic [OP_W-1:0] OP_P_LO = 3'd0;
    localparam logic [OP_W-1:0] OP_P_HI = 3'd1;
    localparam logic [OP_W-1:0] OP_S_LO = 3'd2;
    localparam logic [OP_W-1:0] OP_S_HI = 3'd3;
    localparam logic [OP_W-1:0] OP_T_LO = 3'd4;
    localparam logic [OP_W-1:0] OP_T_HI = 3'd5;
    localparam logic [OP_W-1:0] OP_D_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_D_HI = 3'd7;

    localparam logic [DT_W-1:0]   DT_RESET  = 24'd16777;
    localparam logic [DATA_W-2:0] LIM_RESET = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_CHECK,
        ST_DIV,
        ST_INTEG,
        ST_SUM,
        ST_WRITE
    } state_t;

    typedef struct packed {
        logic mul;
        logic div_chk;
        logic div;
        logic integ;
        logic sum;
        logic out_load;
    } ctrl_t;

    function automatic logic signed [DATA_W-1:0] sat_term(logic [ACC_W-1:0] mag, logic neg);
        logic [ACC_W-1:0]  lim;
        logic [DATA_W-1:0] m;
        lim = ACC_W'(1) << (DATA_W - 1);
        if (!neg) begin
            lim = lim - ACC_W'(1);
        end
        m = (mag > lim) ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
        return neg ? signed'(-m) : signed'(m);
    endfunction

    function automatic logic signed [DATA_W-1:0] clamp_sym(logic signed [DATA_W+1:0] v,
                                                         logic [DATA_W-2:0] lim);
        logic signed [DATA_W+1:0] lim_s;
        logic signed [DATA_W+1:0] res;
        lim_s = signed'({3'b000, lim});
        if (v > lim_s) begin
            res = lim_s;
        end else if (v < -lim_s) begin
            res = -lim_s;
        end else begin
            res = v;
        end
        return res[DATA_W-1:0];
    endfunction

endpackage

/* sv/pid_trapezoid_clamped_core.sv */
// PID step with trapezoidal integral and clamps, on one shared multiplier and a serial divider.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | s_valid / s_ready    | s_error_sample
//  result   | m_valid / m_ready    | m_drive, m_integrator_out
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Per sample, from its transfer to a loaded result register, the core runs eight passes of
// the shared 65 x 16 bit multiplier, one overflow check, 32 restoring divider steps for the
// derivative, the integrator update, the sum and clamp, and the load; a new sample waits for
// that load. A saturated derivative skips the divider. Reset is synchronous, restores the
// register defaults and clears the integrator and the previous error. A stalled result holds
// its register while the next sample is computed; only the final load waits for it to go.
module pid_trapezoid_clamped_core (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [pidtc_pkg::DATA_W-1:0]    s_error_sample,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [pidtc_pkg::DATA_W-1:0]    m_drive,
    output logic signed [pidtc_pkg::DATA_W-1:0]    m_integrator_out,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [pidtc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pidtc_pkg::DATA_W-1:0]           cfg_data
);
    import pidtc_pkg::*;

    state_t state_reg, state_next;
    ctrl_t  ctrl;

    logic signed [DATA_W-1:0] kp_reg, ki_reg, kd_reg;
    logic [DT_W-1:0]          dt_reg;
    logic [DATA_W-2:0]        ilim_reg, dlim_reg;

    logic signed [DATA_W-1:0] prev_err_reg, integ_reg;
    logic signed [DATA_W-1:0] e_reg;
    logic [MAG_W-1:0]         mag_e_reg, mag_s_reg, mag_df_reg;
    logic                     neg_p_reg, neg_i_reg, neg_d_reg;

    logic [OP_W-1:0]          op_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic [OPA_W-1:0]         m1_reg;
    logic [DT_W-1:0]          rem_reg, rem_next;
    logic [QUO_W-1:0]         quo_reg, quo_next;

    logic signed [DATA_W-1:0] p_reg, inc_reg, d_reg, drive_reg;
    logic signed [DATA_W-1:0] m_drive_reg, m_integ_reg;
    logic                     m_valid_reg;

    logic                     accept;
    logic signed [DATA_W:0]   sum_s, diff_s;
    logic [DATA_W-1:0]        mag_kp, mag_ki, mag_kd;
    logic [DT_W-1:0]          dt_eff;
    logic [OPA_W-1:0]         a_op;
    logic [CHUNK_W-1:0]       b_op;
    logic [PP_W-1:0]          pp;
    logic [PP_W+CHUNK_W-1:0]  pp_sh;
    logic [DT_W:0]            div_t;
    logic                     div_ge;
    logic                     d_over;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid          = m_valid_reg;
    assign m_drive          = m_drive_reg;
    assign m_integrator_out = m_integ_reg;

    assign sum_s  = {s_error_sample[DATA_W-1], s_error_sample} +
                    {prev_err_reg[DATA_W-1], prev_err_reg};
    assign diff_s = {s_error_sample[DATA_W-1], s_error_sample} -
                    {prev_err_reg[DATA_W-1], prev_err_reg};

    assign mag_kp = kp_reg[DATA_W-1] ? (~kp_reg + 1'b1) : kp_reg;
    assign mag_ki = ki_reg[DATA_W-1] ? (~ki_reg + 1'b1) : ki_reg;
    assign mag_kd = kd_reg[DATA_W-1] ? (~kd_reg + 1'b1) : kd_reg;
    assign dt_eff = (dt_reg == '0) ? DT_W'(1) : dt_reg;

    always_comb begin
        case (op_reg)
            OP_P_LO: begin a_op = OPA_W'(mag_e_reg);  b_op = mag_kp[CHUNK_W-1:0];        end
            OP_P_HI: begin a_op = OPA_W'(mag_e_reg);  b_op = mag_kp[DATA_W-1:CHUNK_W];   end
            OP_S_LO: begin a_op = OPA_W'(mag_s_reg);  b_op = mag_ki[CHUNK_W-1:0];        end
            OP_S_HI: begin a_op = OPA_W'(mag_s_reg);  b_op = mag_ki[DATA_W-1:CHUNK_W];   end
            OP_T_LO: begin a_op = m1_reg;             b_op = dt_eff[CHUNK_W-1:0];        end
            OP_T_HI: begin a_op = m1_reg;             b_op = CHUNK_W'(dt_eff[DT_W-1:CHUNK_W]); end
            OP_D_LO: begin a_op = OPA_W'(mag_df_reg); b_op = mag_kd[CHUNK_W-1:0];        end
            OP_D_HI: begin a_op = OPA_W'(mag_df_reg); b_op = mag_kd[DATA_W-1:CHUNK_W];   end
            default: begin a_op = '0;                 b_op = '0;                         end
        endcase
    end

    assign pp    = PP_W'(a_op) * PP_W'(b_op);
    assign pp_sh = op_reg[0] ? {pp, {CHUNK_W{1'b0}}} : {{CHUNK_W{1'b0}}, pp};
    assign acc_next = (op_reg[0] ? acc_reg : '0) + pp_sh[ACC_W-1:0];

    assign d_over   = m1_reg[OPA_W-1:D_SHIFT+QUO_W-DT_W+DT_W-D_SHIFT-QUO_W+QUO_W-D_SHIFT]
                      >= (OPA_W-(QUO_W-D_SHIFT))'(dt_eff);
    assign div_t    = {rem_reg, quo_reg[QUO_W-1]};
    assign div_ge   = div_t >= {1'b0, dt_eff};
    assign rem_next = div_ge ? DT_W'(div_t - {1'b0, dt_eff}) : div_t[DT_W-1:0];
    assign quo_next = {quo_reg[QUO_W-2:0], div_ge};

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (accept) state_next = ST_MUL;
            ST_MUL:       if (op_reg == OP_D_HI) state_next = ST_DIV_CHECK;
            ST_DIV_CHECK: state_next = d_over ? ST_INTEG : ST_DIV;
            ST_DIV:       if (cnt_reg == CNT_W'(QUO_W - 1)) state_next = ST_INTEG;
            ST_INTEG:     state_next = ST_SUM;
            ST_SUM:       state_next = ST_WRITE;
            ST_WRITE:     if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = 1'b0;
        ctrl          = '0;
        case (state_reg)
            ST_IDLE:      s_ready = 1'b1;
            ST_MUL:       ctrl.mul = 1'b1;
            ST_DIV_CHECK: ctrl.div_chk = 1'b1;
            ST_DIV:       ctrl.div = 1'b1;
            ST_INTEG:     ctrl.integ = 1'b1;
            ST_SUM:       ctrl.sum = 1'b1;
            ST_WRITE:     ctrl.out_load = !m_valid_reg || m_ready;
            default:      s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            op_reg       <= '0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            kp_reg       <= '0;
            ki_reg       <= '0;
            kd_reg       <= '0;
            dt_reg       <= DT_RESET;
            ilim_reg     <= LIM_RESET;
            dlim_reg     <= LIM_RESET;
            prev_err_reg <= '0;
            integ_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_PROP_GAIN:        kp_reg   <= signed'(cfg_data);
                    REG_INTEGRAL_GAIN:    ki_reg   <= signed'(cfg_data);
                    REG_DERIV_GAIN:       kd_reg   <= signed'(cfg_data);
                    REG_LOOP_PERIOD:      dt_reg   <= cfg_data[DT_W-1:0];
                    REG_INTEGRATOR_LIMIT: ilim_reg <= cfg_data[DATA_W-2:0];
                    REG_DRIVE_LIMIT:      dlim_reg <= cfg_data[DATA_W-2:0];
                    default:              ;
                endcase
            end
            if (accept) begin
                op_reg <= '0;
            end else if (ctrl.mul) begin
                op_reg <= op_reg + 1'b1;
            end
            if (ctrl.div_chk) begin
                cnt_reg <= '0;
            end else if (ctrl.div) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctrl.integ) begin
                integ_reg    <= clamp_sym((DATA_W+2)'(integ_reg) + (DATA_W+2)'(inc_reg),
                                          ilim_reg);
                prev_err_reg <= e_reg;
            end
            if (ctrl.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            e_reg      <= s_error_sample;
            mag_e_reg  <= s_error_sample[DATA_W-1] ? MAG_W'(-(MAG_W'(s_error_sample)))
                                                   : MAG_W'(s_error_sample);
            mag_s_reg  <= sum_s[DATA_W] ? MAG_W'(-sum_s) : MAG_W'(sum_s);
            mag_df_reg <= diff_s[DATA_W] ? MAG_W'(-diff_s) : MAG_W'(diff_s);
            neg_p_reg  <= kp_reg[DATA_W-1] ^ s_error_sample[DATA_W-1];
            neg_i_reg  <= ki_reg[DATA_W-1] ^ sum_s[DATA_W];
            neg_d_reg  <= kd_reg[DATA_W-1] ^ diff_s[DATA_W];
        end
        if (ctrl.mul) begin
            acc_reg <= acc_next;
            case (op_reg)
                OP_P_HI: p_reg   <= sat_term(acc_next >> FRAC_BITS, neg_p_reg);
                OP_S_HI: m1_reg  <= acc_next[OPA_W-1:0];
                OP_T_HI: inc_reg <= sat_term(acc_next >> I_SHIFT, neg_i_reg);
                OP_D_HI: m1_reg  <= acc_next[OPA_W-1:0];
                default: ;
            endcase
        end
        if (ctrl.div_chk) begin
            if (d_over) begin
                d_reg <= sat_term('1, neg_d_reg);
            end else begin
                rem_reg <= m1_reg[QUO_W-D_SHIFT+DT_W-1:QUO_W-D_SHIFT];
                quo_reg <= {m1_reg[QUO_W-D_SHIFT-1:0], {D_SHIFT{1'b0}}};
            end
        end
        if (ctrl.div) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (cnt_reg == CNT_W'(QUO_W - 1)) begin
                d_reg <= sat_term(ACC_W'(quo_next), neg_d_reg);
            end
        end
        if (ctrl.sum) begin
            drive_reg <= clamp_sym((DATA_W+2)'(p_reg) + (DATA_W+2)'(integ_reg) +
                                   (DATA_W+2)'(d_reg), dlim_reg);
        end
        if (ctrl.out_load) begin
            m_drive_reg <= drive_reg;
            m_integ_reg <= integ_reg;
        end
    end

endmodule
